### rtl/core/bplg_pkg.sv
`default_nettype none
package bplg_pkg;

  localparam int unsigned TableEntries   = 1024;
  localparam int unsigned HistoryEntries = 4096;
  localparam int unsigned HistoryBits    = 10;
  localparam int unsigned CtrW           = 10;
  localparam int unsigned AddrW          = 32;

  // register indexes on the config port
  localparam logic [1:0] RegPlacement = 2'd0;
  localparam logic [1:0] RegCtrBits   = 2'd1;
  localparam logic [1:0] RegMask      = 2'd2;

  // placement modes
  localparam logic [1:0] ModeLru  = 2'd0;
  localparam logic [1:0] ModeFifo = 2'd1;

  typedef struct packed {
    logic [AddrW-1:0] branch_address;
    logic             taken;
  } item_t;

  typedef struct packed {
    logic local_prediction;
    logic local_correct;
    logic local_tag_hit;
    logic share_prediction;
    logic share_correct;
  } result_t;

  typedef struct packed {
    logic [AddrW-1:0] tag;
    logic             valid;
    logic [CtrW-1:0]  ctr;
  } entry_t;

  // update control broadcast to every cell of the chain
  typedef struct packed {
    logic             upd;
    logic             lru;
    logic             fifo;
    logic             dm;
    logic             none;
    logic [AddrW-1:0] addr;
    logic [CtrW-1:0]  cn;
  } cell_ctl_t;

  // saturate, predict, update: returns {prediction, next counter}
  function automatic logic [CtrW:0] use_ctr(input logic [CtrW-1:0] ctr,
                                            input logic [3:0] bits,
                                            input logic taken);
    logic [3:0]      w;
    logic [CtrW-1:0] mx;
    logic [CtrW-1:0] c;
    logic            pred;
    w = bits;
    if (w < 4'd2) w = 4'd2;
    if (w > 4'd10) w = 4'd10;
    mx = CtrW'((11'd1 << w) - 11'd1);
    c = (ctr > mx) ? mx : ctr;
    pred = (c > (mx >> 1));
    if (taken) begin
      if (c < mx) c = c + 1'b1;
    end else begin
      if (c != '0) c = c - 1'b1;
    end
    return {pred, c};
  endfunction

endpackage
`default_nettype wire

### rtl/core/bplg_ram.sv
`default_nettype none
module bplg_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/bplg_cell.sv
`default_nettype none
module bplg_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned IdxW = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bplg_pkg::cell_ctl_t   ctl_i,
  input  wire logic [IdxW-1:0]       ptr_i,
  input  wire bplg_pkg::entry_t      prev_i,
  input  wire logic                  before_i,
  output bplg_pkg::entry_t           entry_o,
  output logic                       before_o,
  output logic                       hit_o,
  output logic [bplg_pkg::CtrW-1:0]  ctr_o
);
  import bplg_pkg::*;

  entry_t entry_q, entry_d;
  logic stop, first, dmsel, tag_eq, tgt, shift;

  assign tag_eq   = (entry_q.tag == ctl_i.addr);
  assign stop     = !entry_q.valid || tag_eq;
  assign first    = stop && !before_i;
  assign before_o = before_i || stop;
  assign dmsel    = (ctl_i.addr[IdxW-1:0] == IdxW'(Idx));
  assign hit_o    = ctl_i.dm ? (dmsel && entry_q.valid && tag_eq) : (first && entry_q.valid);
  assign ctr_o    = hit_o ? entry_q.ctr : '0;
  assign entry_o  = entry_q;

  always_comb begin
    if (ctl_i.lru) tgt = (Idx == 0);
    else if (ctl_i.fifo) tgt = ctl_i.none ? (ptr_i == IdxW'(Idx)) : first;
    else tgt = dmsel;
  end

  // lru shifts every entry up to the first stop down by one
  assign shift = ctl_i.lru && (Idx != 0) && !before_i;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.upd) begin
      if (tgt) entry_d = '{tag: ctl_i.addr, valid: 1'b1, ctr: ctl_i.cn};
      else if (shift) entry_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end
endmodule
`default_nettype wire

### rtl/core/branch_predictor_local_and_gshare.sv
`default_nettype none
// Local tagged counter table plus gshare predictor, updated once per resolved
// branch. Pulse start with an item while busy is low; exactly one result comes
// back on result_o with done_o high for one cycle, after the start transaction
// passes the history read, the local chain lookup and update, and the gshare
// counter read and update. A new transaction is taken in the cycle done_o is
// high, so items do not overlap: the next is taken only once the last is
// through. The result cannot be stalled: sample it while done_o is high. The
// local table is a chain of cells, one per entry, each comparing its own tag;
// a first-stop flag ripples down the chain and lru move-to-front is a shift of
// each cell up to the first stop into its neighbor. After reset busy stays
// high while the history and gshare memories are cleared; config writes are
// taken meanwhile. Config registers (APB, 32 bit): 0x0 placement mode, 0x4
// counter bits, 0x8 index mask; write them only while the block is idle.
// Table sizes must be powers of two.
module branch_predictor_local_and_gshare #(
  parameter int unsigned TABLE_ENTRIES   = bplg_pkg::TableEntries,
  parameter int unsigned HISTORY_ENTRIES = bplg_pkg::HistoryEntries,
  parameter int unsigned HISTORY_BITS    = bplg_pkg::HistoryBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire bplg_pkg::item_t   item_i,
  output logic                   done_o,
  output bplg_pkg::result_t      result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import bplg_pkg::*;

  localparam int unsigned TiW = $clog2(TABLE_ENTRIES);
  localparam int unsigned HiW = $clog2(HISTORY_ENTRIES);
  localparam int unsigned Clr = (HISTORY_ENTRIES > TABLE_ENTRIES) ? HISTORY_ENTRIES
                                                                  : TABLE_ENTRIES;
  localparam int unsigned ClrW = $clog2(Clr);

  typedef enum logic [1:0] {StIdle, StLook, StShare} state_e;

  // config registers
  logic [1:0] mode_q;
  logic [3:0] bits_q;
  logic [9:0] mask_q;
  logic       cfg_wr;

  // control
  state_e            state_q;
  logic              clearing_q;
  logic [ClrW-1:0]   clr_q;
  logic [TiW-1:0]    ptr_q;
  logic              done_q;
  result_t           result_q;

  // per-item payload
  logic [AddrW-1:0]  addr_q;
  logic              taken_q;
  logic              lp_q, hit_q;
  logic [TiW-1:0]    gidx_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = clearing_q || (state_q != StIdle);
  assign done_o = done_q;
  assign result_o = result_q;

  // apb port: always ready, writes land on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      RegPlacement: prdata = {30'd0, mode_q};
      RegCtrBits:   prdata = {28'd0, bits_q};
      RegMask:      prdata = {22'd0, mask_q};
      default:      prdata = '0;
    endcase
  end

  // history memory: read on accept, written back in the lookup cycle
  logic [HISTORY_BITS-1:0] hist_rd, hist_new, hist_wd;
  logic [HISTORY_BITS:0]   hist_sh;
  logic                    hist_we;
  logic [HiW-1:0]          hist_wa;

  assign hist_sh  = {hist_rd, taken_q};
  assign hist_new = hist_sh[HISTORY_BITS-1:0];
  assign hist_we  = clearing_q || (state_q == StLook);
  assign hist_wa  = clearing_q ? clr_q[HiW-1:0] : addr_q[HiW-1:0];
  assign hist_wd  = clearing_q ? '0 : hist_new;

  bplg_ram #(.Width(HISTORY_BITS), .Depth(HISTORY_ENTRIES)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_wa),
    .wdata_i (hist_wd),
    .raddr_i (item_i.branch_address[HiW-1:0]),
    .rdata_o (hist_rd)
  );

  // gshare index from history xor address, masked
  logic [AddrW-1:0] gx;
  logic [TiW-1:0]   gidx;
  assign gx   = ({{(AddrW-HISTORY_BITS){1'b0}}, hist_rd} ^ addr_q) & {22'd0, mask_q};
  assign gidx = gx[TiW-1:0];

  // gshare counter memory: read in lookup, updated in share cycle
  logic [CtrW-1:0] sh_rd, sh_wd;
  logic [CtrW:0]   sh_use;
  logic            sh_we;
  logic [TiW-1:0]  sh_wa;

  assign sh_use = use_ctr(sh_rd, bits_q, taken_q);
  assign sh_we  = clearing_q || (state_q == StShare);
  assign sh_wa  = clearing_q ? clr_q[TiW-1:0] : gidx_q;
  assign sh_wd  = clearing_q ? '0 : sh_use[CtrW-1:0];

  bplg_ram #(.Width(CtrW), .Depth(TABLE_ENTRIES)) u_share (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_wa),
    .wdata_i (sh_wd),
    .raddr_i (gidx),
    .rdata_o (sh_rd)
  );

  // local table: chain of cells
  cell_ctl_t       ctl;
  entry_t          ent   [TABLE_ENTRIES];
  entry_t          prev  [TABLE_ENTRIES];
  logic            bef   [TABLE_ENTRIES+1];
  logic            chit  [TABLE_ENTRIES];
  logic [CtrW-1:0] cctr  [TABLE_ENTRIES];
  logic            lhit;
  logic [CtrW-1:0] lold;
  logic [CtrW:0]   luse;

  assign bef[0] = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = '0;
    end else begin : g_body
      assign prev[i] = ent[i-1];
    end
    bplg_cell #(.Idx(i), .IdxW(TiW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .ptr_i    (ptr_q),
      .prev_i   (prev[i]),
      .before_i (bef[i]),
      .entry_o  (ent[i]),
      .before_o (bef[i+1]),
      .hit_o    (chit[i]),
      .ctr_o    (cctr[i])
    );
  end

  // at most one cell reports a hit, so an or across the row selects it
  always_comb begin
    lhit = 1'b0;
    lold = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      lhit = lhit | chit[i];
      lold = lold | cctr[i];
    end
  end

  // new entries start at zero
  assign luse = use_ctr(lhit ? lold : '0, bits_q, taken_q);

  always_comb begin
    ctl.upd  = (state_q == StLook);
    ctl.lru  = (mode_q == ModeLru);
    ctl.fifo = (mode_q == ModeFifo);
    ctl.dm   = !ctl.lru && !ctl.fifo;
    ctl.none = !bef[TABLE_ENTRIES];
    ctl.addr = addr_q;
    ctl.cn   = luse[CtrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeLru;
      bits_q     <= 4'd2;
      mask_q     <= 10'd31;
      state_q    <= StIdle;
      clearing_q <= 1'b1;
      clr_q      <= '0;
      ptr_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          RegPlacement: mode_q <= pwdata[1:0];
          RegCtrBits:   bits_q <= pwdata[3:0];
          RegMask:      mask_q <= pwdata[9:0];
          default:      ;
        endcase
      end
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == ClrW'(Clr - 1)) clearing_q <= 1'b0;
      end
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) state_q <= StLook;
        end
        StLook: begin
          // fifo pointer moves only when a full table replaces an entry
          if (ctl.fifo && ctl.none && !lhit) ptr_q <= ptr_q + 1'b1;
          state_q <= StShare;
        end
        StShare: begin
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= item_i.branch_address;
      taken_q <= item_i.taken;
    end
    if (state_q == StLook) begin
      lp_q   <= luse[CtrW];
      hit_q  <= lhit;
      gidx_q <= gidx;
    end
    if (state_q == StShare) begin
      result_q.local_prediction <= lp_q;
      result_q.local_correct    <= (lp_q == taken_q);
      result_q.local_tag_hit    <= hit_q;
      result_q.share_prediction <= sh_use[CtrW];
      result_q.share_correct    <= (sh_use[CtrW] == taken_q);
    end
  end

`ifndef SYNTH
  a_done_after_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StShare))
    else $error("result strobe without a share cycle");
  a_look_then_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLook) |=> (state_q == StShare))
    else $error("lookup not followed by share cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("accepted transaction did not raise busy");
  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (state_q == StIdle))
    else $error("item in flight during memory clear");
`endif
endmodule
`default_nettype wire
